@@ rtl/brm_pkg.sv @@
// ----------------------------------------------------------------------------
// brm_pkg
// Types and constants shared by the BitBus reply matcher modules.
// ----------------------------------------------------------------------------
package brm_pkg;

  localparam int unsigned SlotsDefault = 8;
  localparam int unsigned HdrBytes     = 4;
  localparam int unsigned LinkExtra    = 3;

  typedef enum logic [1:0] {
    MODE_POST = 2'd0,
    MODE_DATA = 2'd1,
    MODE_END  = 2'd2,
    MODE_TICK = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    K_MATCH    = 3'd0,
    K_UNSOL    = 3'd1,
    K_STORED   = 3'd2,
    K_DROPPED  = 3'd3,
    K_COMPLETE = 3'd4,
    K_STRAY    = 3'd5,
    K_TIMEOUT  = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    PH_WAIT   = 3'd0,
    PH_HEADER = 3'd1,
    PH_STATUS = 3'd2,
    PH_BODY   = 3'd3,
    PH_IGNORE = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_EXEC   = 3'd1,
    ST_SEARCH = 3'd2,
    ST_SCAN   = 3'd3
  } state_e;

  typedef struct packed {
    logic       in_item;
    logic [1:0] mode;
    logic       exec;
    logic       search_start;
    logic       search_step;
    logic       match_done;
    logic       scan_start;
    logic       scan_step;
    logic       out_load;
    logic       out_last;
  } ctrl_t;

  typedef struct packed {
    logic search_done;
    logic scan_done;
    logic scan_hit;
    logic scan_more;
    logic need_search;
    logic exec_emits;
  } stat_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data;
    logic [2:0] slot;
    logic [7:0] node;
    logic [7:0] tasks;
    logic [7:0] max_len;
    logic [7:0] age_limit;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] slot_out;
    logic [7:0] byte_out;
    logic [7:0] body_offset;
    logic [7:0] hdr_length;
    logic [7:0] hdr_route;
    logic [7:0] hdr_node;
    logic [7:0] hdr_tasks;
    logic       overflowed;
    logic       last;
  } out_item_t;

endpackage

@@ rtl/brm_if.sv @@
// ----------------------------------------------------------------------------
// brm_in_if / brm_out_if
// Valid/ready channels carrying input and result items.
// ----------------------------------------------------------------------------
interface brm_in_if;
  logic             valid;
  logic             ready;
  brm_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface brm_out_if;
  logic              valid;
  logic              ready;
  brm_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/brm_ctrl.sv @@
// ----------------------------------------------------------------------------
// brm_ctrl
// Sequencer: accept an item, run the table search or watchdog scan, and
// hand each result to the output register.
// ----------------------------------------------------------------------------
module brm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     in_mode_i,
  output logic           in_ready_o,
  input  logic           out_busy_i,
  input  brm_pkg::stat_t stat_i,
  output brm_pkg::ctrl_t ctrl_o
);
  import brm_pkg::*;

  state_e state_q, state_d;
  logic [1:0] mode_q, mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= MODE_POST;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    ctrl_o     = '0;
    ctrl_o.mode = mode_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        ctrl_o.in_item = in_valid_i;
        if (in_valid_i) begin
          mode_d  = in_mode_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // status byte needs the search before anything else
        if (mode_q == MODE_TICK) begin
          ctrl_o.scan_start = 1'b1;
          state_d = ST_SCAN;
        end else if (stat_i.need_search && mode_q == MODE_DATA &&
                     !out_busy_i) begin
          ctrl_o.exec = 1'b1;
          ctrl_o.search_start = 1'b1;
          state_d = ST_SEARCH;
        end else if (mode_q == MODE_POST) begin
          ctrl_o.exec = 1'b1;
          state_d = ST_IDLE;
        end else if (mode_q == MODE_DATA && !stat_i.exec_emits) begin
          ctrl_o.exec = 1'b1;
          state_d = ST_IDLE;
        end else if (!out_busy_i) begin
          ctrl_o.exec     = 1'b1;
          ctrl_o.out_load = 1'b1;
          ctrl_o.out_last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SEARCH: begin
        if (stat_i.search_done) begin
          if (!out_busy_i) begin
            ctrl_o.match_done = 1'b1;
            ctrl_o.out_load   = 1'b1;
            ctrl_o.out_last   = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          ctrl_o.search_step = 1'b1;
        end
      end
      ST_SCAN: begin
        // one slot per cycle; wait on a hit until the output is free
        if (stat_i.scan_hit) begin
          if (!out_busy_i) begin
            ctrl_o.scan_step = 1'b1;
            ctrl_o.out_load  = 1'b1;
            ctrl_o.out_last  = !stat_i.scan_more;
            if (stat_i.scan_done) state_d = ST_IDLE;
          end
        end else begin
          ctrl_o.scan_step = 1'b1;
          if (stat_i.scan_done) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

@@ rtl/brm_dp.sv @@
// ----------------------------------------------------------------------------
// brm_dp
// Transaction table, receive state, search and aging datapath, and the
// output register.
// ----------------------------------------------------------------------------
module brm_dp #(
  parameter int unsigned Slots = brm_pkg::SlotsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  brm_pkg::in_item_t  in_item_i,
  input  brm_pkg::ctrl_t     ctrl_i,
  output brm_pkg::stat_t     stat_o,
  output logic               out_busy_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output brm_pkg::out_item_t out_item_o
);
  import brm_pkg::*;

  localparam int unsigned IdxW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned CntW = $clog2(Slots + 1);

  in_item_t   item_q;
  phase_e     phase_q;
  logic [7:0] hdr_q [HdrBytes];
  logic [7:0] rx_count_q;
  logic [IdxW-1:0] cur_slot_q;
  logic       cur_ovf_q;
  logic [Slots-1:0] valid_q;
  logic [7:0] node_q  [Slots];
  logic [7:0] tasks_q [Slots];
  logic [7:0] maxl_q  [Slots];
  logic [7:0] age_q   [Slots];
  logic [7:0] stamp_q [Slots];
  logic [7:0] post_cnt_q;

  // search / scan
  logic [CntW-1:0] idx_q;
  logic            best_vld_q;
  logic [IdxW-1:0] best_q;
  logic [7:0]      best_dist_q;
  logic [IdxW-1:0] idx;
  logic [7:0]      post_gap;
  logic            cand;
  logic            scan_hit;
  logic            scan_more;

  // output register
  logic      ovld_q;
  out_item_t obuf_q;
  out_item_t res;
  logic      res_vld;

  assign idx  = idx_q[IdxW-1:0];
  assign post_gap = post_cnt_q - stamp_q[idx];
  assign cand = valid_q[idx] && node_q[idx] == hdr_q[2] && tasks_q[idx] == hdr_q[3];
  assign scan_hit = valid_q[idx] && age_q[idx] <= 8'd1;

  // a later slot still times out on this tick
  always_comb begin
    scan_more = 1'b0;
    for (int i = 0; i < Slots; i++) begin
      if (CntW'(i) > idx_q && valid_q[i] && age_q[i] <= 8'd1) scan_more = 1'b1;
    end
  end

  assign stat_o.search_done = (idx_q == CntW'(Slots));
  assign stat_o.scan_done   = (idx_q == CntW'(Slots - 1));
  assign stat_o.scan_hit    = scan_hit;
  assign stat_o.scan_more   = scan_more;
  assign stat_o.need_search = (phase_q == PH_STATUS);
  assign stat_o.exec_emits  = (phase_q != PH_WAIT) && (phase_q != PH_HEADER);

  assign out_busy_o  = ovld_q && !out_ready_i;
  assign out_valid_o = ovld_q;
  assign out_item_o  = obuf_q;

  logic body_drop;
  assign body_drop = cur_ovf_q || rx_count_q >= maxl_q[cur_slot_q];

  always_comb begin
    res = '0;
    res.hdr_length = hdr_q[0];
    res.hdr_route  = hdr_q[1];
    res.hdr_node   = hdr_q[2];
    res.hdr_tasks  = hdr_q[3];
    res.last       = ctrl_i.out_last;
    res.byte_out   = item_q.data;
    if (ctrl_i.match_done) begin
      res.kind     = best_vld_q ? K_MATCH : K_UNSOL;
      res.slot_out = best_vld_q ? 3'(best_q) : 3'd0;
    end else if (ctrl_i.mode == MODE_TICK) begin
      res.kind     = K_TIMEOUT;
      res.slot_out = 3'(idx);
      res.byte_out = 8'd0;
    end else if (ctrl_i.mode == MODE_END) begin
      res.kind       = (phase_q == PH_BODY) ? K_COMPLETE : K_STRAY;
      res.slot_out   = (phase_q == PH_BODY) ? 3'(cur_slot_q) : 3'd0;
      res.overflowed = (phase_q == PH_BODY) && cur_ovf_q;
    end else if (phase_q == PH_BODY) begin
      res.slot_out = 3'(cur_slot_q);
      if (body_drop) begin
        res.kind       = K_DROPPED;
        res.overflowed = 1'b1;
      end else begin
        res.kind        = K_STORED;
        res.body_offset = rx_count_q - 8'(HdrBytes + LinkExtra);
      end
    end else begin
      res.kind = K_DROPPED;
    end
  end

  assign res_vld = ctrl_i.out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (res_vld) begin
      ovld_q <= 1'b1;
    end else if (out_ready_i) begin
      ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      obuf_q <= res;
    end
    if (ctrl_i.in_item) item_q <= in_item_i;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec && item_q.mode == MODE_POST && 32'(item_q.slot) < Slots) begin
      node_q[IdxW'(item_q.slot)]  <= item_q.node;
      tasks_q[IdxW'(item_q.slot)] <= item_q.tasks;
      maxl_q[IdxW'(item_q.slot)]  <= item_q.max_len;
      stamp_q[IdxW'(item_q.slot)] <= post_cnt_q;
    end
    if (ctrl_i.exec && item_q.mode == MODE_POST && 32'(item_q.slot) < Slots) begin
      age_q[IdxW'(item_q.slot)] <= item_q.age_limit;
    end else if (ctrl_i.scan_step && valid_q[idx]) begin
      if (scan_hit) age_q[idx] <= 8'd0;
      else if (age_q[idx] != 8'd0) age_q[idx] <= age_q[idx] - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_WAIT;
      for (int i = 0; i < HdrBytes; i++) hdr_q[i] <= 8'd0;
      rx_count_q <= 8'd0;
      cur_slot_q <= '0;
      cur_ovf_q  <= 1'b0;
      valid_q    <= '0;
      post_cnt_q <= 8'd0;
      idx_q      <= '0;
      best_vld_q <= 1'b0;
      best_q     <= '0;
      best_dist_q <= 8'd0;
    end else begin
      if (ctrl_i.exec) begin
        unique case (item_q.mode)
          MODE_POST: begin
            if (32'(item_q.slot) < Slots) begin
              valid_q[IdxW'(item_q.slot)] <= 1'b1;
              post_cnt_q <= post_cnt_q + 8'd1;
            end
          end
          MODE_DATA: begin
            case (phase_q)
              PH_WAIT: begin
                hdr_q[0]   <= item_q.data;
                rx_count_q <= 8'd1;
                phase_q    <= PH_HEADER;
              end
              PH_HEADER: begin
                hdr_q[rx_count_q[1:0]] <= item_q.data;
                rx_count_q <= rx_count_q + 8'd1;
                if (rx_count_q + 8'd1 >= 8'(HdrBytes)) phase_q <= PH_STATUS;
              end
              PH_STATUS: begin
                rx_count_q <= rx_count_q + 8'(LinkExtra);
                cur_ovf_q  <= 1'b0;
              end
              PH_BODY: begin
                if (body_drop) cur_ovf_q <= 1'b1;
                else rx_count_q <= rx_count_q + 8'd1;
              end
              default: ;
            endcase
          end
          MODE_END: begin
            phase_q    <= PH_WAIT;
            rx_count_q <= 8'd0;
            cur_ovf_q  <= 1'b0;
          end
          default: ;
        endcase
      end
      if (ctrl_i.search_start || ctrl_i.scan_start) begin
        idx_q      <= '0;
        best_vld_q <= 1'b0;
      end else if (ctrl_i.search_step) begin
        if (cand && (!best_vld_q || post_gap > best_dist_q)) begin
          best_vld_q  <= 1'b1;
          best_q      <= idx;
          best_dist_q <= post_gap;
        end
        idx_q <= idx_q + CntW'(1);
      end else if (ctrl_i.scan_step) begin
        if (scan_hit) valid_q[idx] <= 1'b0;
        if (!stat_o.scan_done) idx_q <= idx_q + CntW'(1);
      end
      if (ctrl_i.match_done) begin
        if (best_vld_q) begin
          cur_slot_q      <= best_q;
          valid_q[best_q] <= 1'b0;
          phase_q         <= PH_BODY;
        end else begin
          phase_q <= PH_IGNORE;
        end
      end
    end
  end
endmodule

@@ rtl/bitbus_reply_matcher.sv @@
// Sequence: a post or header byte is accepted in IDLE and applied in EXEC;
// a body or end byte also loads the result register there; a status byte
// runs the table search, one slot per cycle; a watchdog tick, the aging scan.
// One item in flight at a time; a waiting result stalls the sequencer.
// Reset clears valid bits and receive state at once; no clearing pass.
// ----------------------------------------------------------------------------
// bitbus_reply_matcher
// Master-side BitBus reply receiver: matches replies to posted transactions.
// ----------------------------------------------------------------------------
module bitbus_reply_matcher #(
  parameter int unsigned Slots = brm_pkg::SlotsDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  brm_in_if.sink    in_if,
  brm_out_if.source out_if
);
  import brm_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  out_busy;

  brm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_mode_i  (in_if.payload.mode),
    .in_ready_o (in_if.ready),
    .out_busy_i (out_busy),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  brm_dp #(.Slots(Slots)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_if.payload),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_busy_o  (out_busy),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_item_o  (out_if.payload)
  );
endmodule
